// ===== hdl/dqs_pkg.sv =====
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and codes for the double-ended queue with search: operation
// and status codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package dqs_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_item;   // capture the accepted operation and value
        logic exec;        // decode the operation, update pointers, start reads
        logic pop_capture; // take the popped entry from the read register
        logic scan_step;   // compare one entry and advance the search
        logic out_load;    // move the pending result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic pop_rd;      // operation is a pop that needs the read data
        logic srch_rd;     // operation is a search over a non-empty store
        logic hit;         // current search entry matches the key
        logic last;        // current search entry is the back entry
    } t_dp_stat;

endpackage

// ===== hdl/dqs_datapath.sv =====
// ----------------------------------------------------------------------------
// dqs_datapath
// Ring store, front pointer, entry count, search index, pending result and
// output registers of the double-ended queue.
// ----------------------------------------------------------------------------
module dqs_datapath
    import dqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic [ST_W-1:0]          o_status,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [POS_W-1:0]         o_position,
    output logic [CNT_W-1:0]         o_entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_key;
    logic [AW-1:0]            r_front;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx;
    logic [DATA_W-1:0]        r_rd_data;
    logic [ST_W-1:0]          r_pst;
    logic signed [DATA_W-1:0] r_pval;
    logic [POS_W-1:0]         r_ppos;
    logic [ST_W-1:0]          r_ost;
    logic signed [DATA_W-1:0] r_oval;
    logic [POS_W-1:0]         r_opos;
    logic [CNT_W-1:0]         r_ocnt;

    logic [AW-1:0] n_front;
    logic [CW-1:0] n_count;
    logic [ST_W-1:0] exec_st;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          full;
    logic          empty;
    logic [CW-1:0] idx_nx;
    logic [AW+POS_W-1:0] idx_ext;
    logic [CW+CNT_W-1:0] cnt_ext;

    // ring position front + offset, both below twice the depth
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                           input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(offset);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign idx_nx  = CW'(r_idx) + CW'(1);
    assign idx_ext = {{POS_W{1'b0}}, r_idx};
    assign cnt_ext = {{CNT_W{1'b0}}, r_count};

    // operation decode
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        exec_st = ST_DONE;
        wr_en   = 1'b0;
        wr_addr = slot(r_front, r_count);
        rd_addr = slot(r_front, idx_nx);
        o_stat.pop_rd  = 1'b0;
        o_stat.srch_rd = 1'b0;
        o_stat.hit     = (r_rd_data == r_key);
        o_stat.last    = (idx_nx == r_count);
        case (r_op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    exec_st = ST_FULL;
                end else begin
                    n_front = slot(r_front, CW'(DEPTH - 1));
                    wr_addr = n_front;
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    exec_st = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    exec_st = ST_EMPTY;
                end else begin
                    rd_addr = r_front;
                    n_front = slot(r_front, CW'(1));
                    n_count = r_count - CW'(1);
                    o_stat.pop_rd = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    exec_st = ST_EMPTY;
                end else begin
                    rd_addr = slot(r_front, r_count - CW'(1));
                    n_count = r_count - CW'(1);
                    o_stat.pop_rd = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (empty) begin
                    exec_st = ST_EMPTY;
                end else begin
                    rd_addr = r_front;
                    o_stat.srch_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // the search step reads the next entry while comparing this one
        if (i_cmd.scan_step) begin
            rd_addr = slot(r_front, idx_nx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_key;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_operation;
            r_key <= i_item_value;
        end
        if (i_cmd.exec) begin
            r_pst  <= exec_st;
            r_pval <= '0;
            r_ppos <= '0;
            r_idx  <= '0;
        end
        if (i_cmd.pop_capture) begin
            r_pval <= r_rd_data;
        end
        if (i_cmd.scan_step) begin
            if (o_stat.hit) begin
                r_pval <= r_key;
                r_ppos <= idx_ext[POS_W-1:0];
            end else if (o_stat.last) begin
                r_pst <= ST_MISSING;
            end else begin
                r_idx <= idx_nx[AW-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_ost  <= r_pst;
            r_oval <= r_pval;
            r_opos <= r_ppos;
            r_ocnt <= cnt_ext[CNT_W-1:0];
        end
    end

    assign o_status       = r_ost;
    assign o_result_value = r_oval;
    assign o_position     = r_opos;
    assign o_entry_count  = r_ocnt;

endmodule

// ===== hdl/dqs_control.sv =====
// ----------------------------------------------------------------------------
// dqs_control
// Sequencer for one operation at a time: decode, memory read for pops,
// entry-by-entry search, and hand-off to the output register.
// ----------------------------------------------------------------------------
module dqs_control
    import dqs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   in_xfer;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_xfer  = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.pop_rd) begin
                    n_state = S_POP;
                end else if (i_stat.srch_rd) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.load_item   = in_xfer;
            S_DECODE: o_cmd.exec        = 1'b1;
            S_POP:    o_cmd.pop_capture = 1'b1;
            S_SCAN:   o_cmd.scan_step   = 1'b1;
            S_DONE:   o_cmd.out_load    = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/deque_with_search.sv =====
// ----------------------------------------------------------------------------
// deque_with_search
// Double-ended queue of signed 32-bit values with front/back push and pop
// and a linear search from the front.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; o_in_stall is high from the transfer
// until the result is loaded into the output register. A push, or an operation
// that reports full, empty or an unknown code, goes from decode to done; a pop
// passes through a read-capture state between them. A search compares one
// entry per cycle through the single read port of the ring store, from the
// front until it matches or reaches the back entry. A result waiting in the
// output register does not block the next input transfer. The store has no
// reset; only written entries are compared or returned.
module deque_with_search
    import dqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ST_W-1:0]          o_status,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [POS_W-1:0]         o_position,
    output logic [CNT_W-1:0]         o_entry_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dqs_control u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dqs_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_item_value   (i_item_value),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_position     (o_position),
        .o_entry_count  (o_entry_count)
    );

endmodule

// ===== hdl/dqs_checker.sv =====
// ----------------------------------------------------------------------------
// dqs_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dqs_checker
    import dqs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [OP_W-1:0]          i_operation,
    input logic signed [DATA_W-1:0] i_item_value,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [ST_W-1:0]          o_status,
    input logic signed [DATA_W-1:0] o_result_value,
    input logic [POS_W-1:0]         o_position,
    input logic [CNT_W-1:0]         o_entry_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_result_value) && $stable(o_position)
            && $stable(o_entry_count))
        else $error("stalled result changed");

    // a stalled input transfer holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_operation)
            && $stable(i_item_value))
        else $error("stalled input changed");

    // one operation at a time: input stalls right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while busy");

    // a full store or a missing key reports no value and no position
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_FULL) || (o_status == ST_MISSING))
            |-> (o_result_value == '0) && (o_position == '0))
        else $error("full or missing status with nonzero value or position");

    // empty status only with an empty store
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> (o_entry_count == '0)
            && (o_result_value == '0))
        else $error("empty status with entries left");

endmodule

bind deque_with_search dqs_checker u_dqs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_operation    (i_operation),
    .i_item_value   (i_item_value),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_result_value (o_result_value),
    .o_position     (o_position),
    .o_entry_count  (o_entry_count)
);
